/* rtl/trimmed_mean_sample_filter_defines.svh */
// ----------------------------------------------------------------------------
// Trimmed mean sample filter assertion macros
// Concurrent check macros used by the filter's group queue; empty when assertions
// are switched off.
// ----------------------------------------------------------------------------
`ifndef TRIMMED_MEAN_SAMPLE_FILTER_DEFINES_SVH
`define TRIMMED_MEAN_SAMPLE_FILTER_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define TMSF_ASSERT_HOLDS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("tmsf check failed");
`define TMSF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmsf sequence check failed");
`else
`define TMSF_ASSERT_HOLDS(label, clk, rst_n, cond)
`define TMSF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* rtl/tmsf_pkg.sv */
// ----------------------------------------------------------------------------
// Trimmed mean sample filter package
// Fixed field widths and constants shared by the filter modules.
// ----------------------------------------------------------------------------
package tmsf_pkg;

    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 24;
    localparam int FRAC_W   = 16;
    localparam int SCALED_W = SAMPLE_W + GAIN_W;
    localparam int TRIM_CNT = 4;

    localparam logic [GAIN_W-1:0]   GAIN_RESET = 24'h01_0000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MIN = 16'h0000;
    localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = 16'hFFFF;

endpackage

/* rtl/tmsf_fifo.sv */
// ----------------------------------------------------------------------------
// Trimmed mean group queue
// Small register queue that decouples the group collector from the
// arithmetic pipeline.
// ----------------------------------------------------------------------------
`include "trimmed_mean_sample_filter_defines.svh"

module tmsf_fifo #(
    parameter int DATA_W = 86,
    parameter int DEPTH  = 2
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [DATA_W-1:0] in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [DATA_W-1:0] out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg < CNT_W'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_data  = mem[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= in_data;
        end
    end

    `TMSF_ASSERT_HOLDS(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(DEPTH))
    `TMSF_ASSERT_HOLDS(a_full_ptrs, aclk, aresetn,
        (count_reg != CNT_W'(DEPTH)) || (wr_ptr_reg == rd_ptr_reg))
    `TMSF_ASSERT_NEXT(a_drain, aclk, aresetn, pop && !push,
        count_reg == $past(count_reg) - 1'b1)
    `TMSF_ASSERT_NEXT(a_first_word, aclk, aresetn, push && (count_reg == '0),
        out_valid && (out_data == $past(in_data)))

endmodule

/* rtl/tmsf_front.sv */
// ----------------------------------------------------------------------------
// Trimmed mean group collector
// Accumulates each group of samples and tracks the two largest and two
// smallest values; hands the finished group record to the queue.
// ----------------------------------------------------------------------------
module tmsf_front #(
    parameter int SAMPLES = 8,
    parameter int SUM_W   = 19
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tmsf_pkg::SAMPLE_W-1:0] in_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [SUM_W+4*tmsf_pkg::SAMPLE_W-1:0] out_data
);

    localparam int CNT_W = $clog2(SAMPLES);

    logic [SUM_W-1:0]              sum_reg, sum_next;
    logic [tmsf_pkg::SAMPLE_W-1:0] hi1_reg, hi1_next;
    logic [tmsf_pkg::SAMPLE_W-1:0] hi2_reg, hi2_next;
    logic [tmsf_pkg::SAMPLE_W-1:0] lo1_reg, lo1_next;
    logic [tmsf_pkg::SAMPLE_W-1:0] lo2_reg, lo2_next;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          is_last;
    logic                          accept;

    assign is_last   = (cnt_reg == CNT_W'(SAMPLES - 1));
    assign in_ready  = is_last ? out_ready : 1'b1;
    assign out_valid = in_valid && is_last;
    assign accept    = in_valid && in_ready;
    assign out_data  = {lo2_next, lo1_next, hi2_next, hi1_next, sum_next};

    always_comb begin
        sum_next = sum_reg + SUM_W'(in_sample);
        hi1_next = hi1_reg;
        hi2_next = hi2_reg;
        lo1_next = lo1_reg;
        lo2_next = lo2_reg;
        priority if (in_sample > hi1_reg) begin
            hi2_next = hi1_reg;
            hi1_next = in_sample;
        end else if (in_sample > hi2_reg) begin
            hi2_next = in_sample;
        end else begin
            hi2_next = hi2_reg;
        end
        priority if (in_sample < lo1_reg) begin
            lo2_next = lo1_reg;
            lo1_next = in_sample;
        end else if (in_sample < lo2_reg) begin
            lo2_next = in_sample;
        end else begin
            lo2_next = lo2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            hi1_reg <= tmsf_pkg::SAMPLE_MIN;
            hi2_reg <= tmsf_pkg::SAMPLE_MIN;
            lo1_reg <= tmsf_pkg::SAMPLE_MAX;
            lo2_reg <= tmsf_pkg::SAMPLE_MAX;
            cnt_reg <= '0;
        end else if (accept) begin
            if (is_last) begin
                sum_reg <= '0;
                hi1_reg <= tmsf_pkg::SAMPLE_MIN;
                hi2_reg <= tmsf_pkg::SAMPLE_MIN;
                lo1_reg <= tmsf_pkg::SAMPLE_MAX;
                lo2_reg <= tmsf_pkg::SAMPLE_MAX;
                cnt_reg <= '0;
            end else begin
                sum_reg <= sum_next;
                hi1_reg <= hi1_next;
                hi2_reg <= hi2_next;
                lo1_reg <= lo1_next;
                lo2_reg <= lo2_next;
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

endmodule

/* rtl/tmsf_back.sv */
// ----------------------------------------------------------------------------
// Trimmed mean arithmetic pipeline
// Drops the extremes, divides by the kept sample count through a
// reciprocal multiply, applies the gain and saturates the result.
// ----------------------------------------------------------------------------
module tmsf_back #(
    parameter int SAMPLES = 8,
    parameter int SUM_W   = 19
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [tmsf_pkg::GAIN_W-1:0]   gain,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [SUM_W+4*tmsf_pkg::SAMPLE_W-1:0] in_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tmsf_pkg::SAMPLE_W-1:0] m_tdata
);

    localparam int TRIM_DIV  = (SAMPLES > tmsf_pkg::TRIM_CNT) ?
                               SAMPLES - tmsf_pkg::TRIM_CNT : 1;
    localparam int DIV_SHIFT = SUM_W + $clog2(TRIM_DIV + 1);
    localparam int RECIP_W   = DIV_SHIFT + 1;
    localparam longint unsigned RECIP_VAL = ((64'd1 << DIV_SHIFT) / TRIM_DIV) + 64'd1;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
    localparam int PROD_W    = SUM_W + RECIP_W;
    localparam int SW        = tmsf_pkg::SAMPLE_W;
    localparam int DROP_W    = SW + 2;

    logic [SUM_W-1:0]  grp_sum;
    logic [SW-1:0]     grp_hi1, grp_hi2, grp_lo1, grp_lo2;
    logic [DROP_W-1:0] drop;
    logic [SUM_W-1:0]  rest;
    logic [PROD_W-1:0] quot_prod;
    logic [tmsf_pkg::SCALED_W-1:0] scaled_prod;
    logic [SW-1:0]     sat_val;

    logic                          v1_reg, v2_reg, v3_reg;
    logic [SUM_W-1:0]              rest_reg;
    logic [SW-1:0]                 mean_reg;
    logic [tmsf_pkg::SCALED_W-1:0] scaled_reg;
    logic                          out_free, rdy3, rdy2, rdy1;

    assign {grp_lo2, grp_lo1, grp_hi2, grp_hi1, grp_sum} = in_data;

    assign drop = DROP_W'(grp_hi1) + DROP_W'(grp_hi2) + DROP_W'(grp_lo1) + DROP_W'(grp_lo2);
    assign rest = (SUM_W'(drop) <= grp_sum) ? grp_sum - SUM_W'(drop) : '0;

    assign quot_prod   = PROD_W'(rest_reg) * PROD_W'(RECIP);
    assign scaled_prod = tmsf_pkg::SCALED_W'(mean_reg) * tmsf_pkg::SCALED_W'(gain);
    assign sat_val     = (scaled_reg[tmsf_pkg::SCALED_W-1:tmsf_pkg::FRAC_W+SW] != '0) ?
                         tmsf_pkg::SAMPLE_MAX : scaled_reg[tmsf_pkg::FRAC_W +: SW];

    assign out_free = !m_tvalid || m_tready;
    assign rdy3     = !v3_reg || out_free;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            m_tvalid <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (out_free) begin
                m_tvalid <= v3_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            rest_reg <= rest;
        end
        if (rdy2 && v1_reg) begin
            mean_reg <= quot_prod[DIV_SHIFT +: SW];
        end
        if (rdy3 && v2_reg) begin
            scaled_reg <= scaled_prod;
        end
        if (out_free && v3_reg) begin
            m_tdata <= sat_val;
        end
    end

endmodule

/* rtl/trimmed_mean_sample_filter.sv */
// ----------------------------------------------------------------------------
// Trimmed mean sample filter
// Samples enter on s_*, one per transaction. After every SAMPLES samples the
// block drops the two largest and two smallest, averages the rest, scales
// by the Q8.16 gain and sends one 16-bit saturated result on m_*.
// cfg_wr_en / cfg_wr_data load the gain; write only while the block is idle.
// Throughput: one sample per cycle. The collector stalls only on the last
// sample of a group when its two-entry queue is full.
// Path: the group record of the last sample passes in order through the queue,
// extreme removal, reciprocal divide, gain multiply and saturate registers.
// Reset: gain returns to 1.0, the group restarts, queue and pipeline empty.
// A stalled m_tready holds the output register; the pipeline behind it keeps
// filling, then the queue, then s_tready drops at the next group end.
// ----------------------------------------------------------------------------
module trimmed_mean_sample_filter #(
    parameter int SAMPLES = 8
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [tmsf_pkg::GAIN_W-1:0]   cfg_wr_data,  // gain (Q8.16)
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tmsf_pkg::SAMPLE_W-1:0] s_tdata,      // [15:0] sample
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tmsf_pkg::SAMPLE_W-1:0] m_tdata       // [15:0] scaled_mean
);

    localparam int SUM_W   = tmsf_pkg::SAMPLE_W + $clog2(SAMPLES);
    localparam int GRP_W   = SUM_W + 4 * tmsf_pkg::SAMPLE_W;
    localparam int Q_DEPTH = 2;

    logic [tmsf_pkg::GAIN_W-1:0] gain_reg;
    logic                        fr_valid, fr_ready;
    logic [GRP_W-1:0]            fr_data;
    logic                        bk_valid, bk_ready;
    logic [GRP_W-1:0]            bk_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= tmsf_pkg::GAIN_RESET;
        end else if (cfg_wr_en) begin
            gain_reg <= cfg_wr_data;
        end
    end

    tmsf_front #(
        .SAMPLES (SAMPLES),
        .SUM_W   (SUM_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (s_tdata),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_data  (fr_data)
    );

    tmsf_fifo #(
        .DATA_W (GRP_W),
        .DEPTH  (Q_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fr_valid),
        .in_ready  (fr_ready),
        .in_data   (fr_data),
        .out_valid (bk_valid),
        .out_ready (bk_ready),
        .out_data  (bk_data)
    );

    tmsf_back #(
        .SAMPLES (SAMPLES),
        .SUM_W   (SUM_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .gain     (gain_reg),
        .in_valid (bk_valid),
        .in_ready (bk_ready),
        .in_data  (bk_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

/* bench/trimmed_mean_sample_filter_tb.sv */
// ----------------------------------------------------------------------------
// Trimmed mean sample filter testbench
// Streams groups of 16-bit samples into the filter under several gain
// settings and random idling on both sides. A local predictor tracks the
// running sum and the two-high / two-low extremes, computes each scaled,
// saturated mean, and the result checker compares every output transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module trimmed_mean_sample_filter_tb;

    localparam int SAMPLES      = 8;
    localparam int SUM_W        = tmsf_pkg::SAMPLE_W + $clog2(SAMPLES);
    localparam int CNT_W        = $clog2(SAMPLES) + 1;
    localparam int TRIM_DIV     = (SAMPLES > tmsf_pkg::TRIM_CNT) ?
                                  SAMPLES - tmsf_pkg::TRIM_CNT : 1;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_LIMIT   = 2000;
    localparam int ITEM_TARGET  = 1700;

    typedef logic [tmsf_pkg::SAMPLE_W-1:0] sample_t;
    typedef logic [tmsf_pkg::GAIN_W-1:0]   gain_t;
    typedef enum {SPREAD_UNIFORM, SPREAD_NARROW, SPREAD_RAILS, SPREAD_FLAT} spread_t;

    logic    aclk;
    logic    aresetn;
    logic    cfg_wr_en;
    gain_t   cfg_wr_data;
    logic    s_tvalid;
    logic    s_tready;
    sample_t s_tdata;
    logic    m_tvalid;
    logic    m_tready;
    sample_t m_tdata;

    // predictor state
    gain_t            filt_gain;
    logic [SUM_W-1:0] group_sum;
    sample_t          high1, high2, low1, low2;
    logic [CNT_W-1:0] group_fill;
    sample_t          expected_means[$];

    int  mismatch_count   = 0;
    int  samples_sent     = 0;
    int  sink_wait        = 0;
    int  sink_hold_cycles = 0;
    bit  src_gaps_on      = 1'b1;
    bit  sink_gaps_on     = 1'b1;

    trimmed_mean_sample_filter #(
        .SAMPLES(SAMPLES)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic void clear_group_state();
        group_sum  = '0;
        high1      = tmsf_pkg::SAMPLE_MIN;
        high2      = tmsf_pkg::SAMPLE_MIN;
        low1       = tmsf_pkg::SAMPLE_MAX;
        low2       = tmsf_pkg::SAMPLE_MAX;
        group_fill = '0;
    endfunction

    function automatic void accumulate_sample(sample_t s);
        logic [SUM_W-1:0]              dropped;
        logic [SUM_W-1:0]              kept;
        logic [SUM_W-1:0]              mean;
        logic [tmsf_pkg::SCALED_W-1:0] product;
        logic [tmsf_pkg::SCALED_W-1:0] whole;
        group_sum = group_sum + SUM_W'(s);
        if (s > high1) begin
            high2 = high1;
            high1 = s;
        end else if (s > high2) begin
            high2 = s;
        end
        if (s < low1) begin
            low2 = low1;
            low1 = s;
        end else if (s < low2) begin
            low2 = s;
        end
        group_fill = group_fill + 1'b1;
        if (group_fill == CNT_W'(SAMPLES)) begin
            dropped = SUM_W'(high1) + SUM_W'(high2) + SUM_W'(low1) + SUM_W'(low2);
            kept    = (group_sum >= dropped) ? group_sum - dropped : '0;
            mean    = kept / SUM_W'(TRIM_DIV);
            product = tmsf_pkg::SCALED_W'(mean) * tmsf_pkg::SCALED_W'(filt_gain);
            whole   = product >> tmsf_pkg::FRAC_W;
            expected_means.push_back(
                (whole > tmsf_pkg::SCALED_W'(tmsf_pkg::SAMPLE_MAX)) ?
                tmsf_pkg::SAMPLE_MAX : whole[tmsf_pkg::SAMPLE_W-1:0]);
            clear_group_state();
        end
    endfunction

    function automatic sample_t pick_sample(spread_t spread, sample_t anchor);
        sample_t s;
        case (spread)
            SPREAD_UNIFORM: s = sample_t'($urandom_range(0, 65535));
            SPREAD_NARROW:  s = anchor ^ sample_t'($urandom_range(0, 3));
            SPREAD_RAILS: begin
                case ($urandom_range(0, 3))
                    0:       s = tmsf_pkg::SAMPLE_MIN;
                    1:       s = tmsf_pkg::SAMPLE_MAX;
                    2:       s = tmsf_pkg::SAMPLE_MIN + 1'b1;
                    default: s = tmsf_pkg::SAMPLE_MAX - 1'b1;
                endcase
            end
            default: s = anchor;
        endcase
        return s;
    endfunction

    function automatic gain_t pick_gain();
        gain_t g;
        case ($urandom_range(0, 5))
            0:       g = '0;
            1:       g = '1;
            2:       g = tmsf_pkg::GAIN_RESET;
            3:       g = gain_t'($urandom_range(0, 24'hFF_FFFF));
            4:       g = gain_t'($urandom_range(24'h00_8000, 24'h02_0000));
            default: g = gain_t'($urandom_range(1, 24'h00_FFFF));
        endcase
        return g;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // call at a falling edge; returns at the falling edge after the transaction
    task automatic send_sample(sample_t value);
        int gap;
        gap = src_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        accumulate_sample(value);
        samples_sent++;
        @(negedge aclk);
    endtask

    task automatic send_group(spread_t spread);
        sample_t anchor;
        anchor = sample_t'($urandom_range(0, 65535));
        repeat (SAMPLES) send_sample(pick_sample(spread, anchor));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_means.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_gain(gain_t value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        filt_gain = value;
    endtask

    task automatic test_directed_groups();
        sample_t mixed [SAMPLES] = '{16'd100, 16'd7, 16'd100, 16'd250,
                                     16'd7, 16'd100, 16'd7, 16'd3};
        src_gaps_on  = 1'b0;
        sink_gaps_on = 1'b0;
        repeat (SAMPLES) send_sample(tmsf_pkg::SAMPLE_MIN);
        repeat (SAMPLES) send_sample(tmsf_pkg::SAMPLE_MAX);
        foreach (mixed[i]) send_sample(mixed[i]);
        wait_drained();
    endtask

    task automatic test_gain_extremes();
        gain_t gains [5] = '{24'h00_0000, 24'hFF_FFFF, 24'h00_0001,
                             tmsf_pkg::GAIN_RESET, 24'h7F_FFFF};
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        foreach (gains[i]) begin
            wait_drained();
            write_gain(gains[i]);
            repeat (SAMPLES) send_sample(tmsf_pkg::SAMPLE_MAX);
            send_group(SPREAD_RAILS);
            send_group(SPREAD_UNIFORM);
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        write_gain(gain_t'($urandom_range(24'h00_8000, 24'h02_0000)));
        src_gaps_on      = 1'b0;
        sink_hold_cycles = 400;
        repeat (12) send_group(SPREAD_UNIFORM);
        wait_drained();
    endtask

    task automatic test_drain_pause();
        src_gaps_on  = 1'b1;
        sink_gaps_on = 1'b1;
        send_group(SPREAD_NARROW);
        send_group(SPREAD_UNIFORM);
        repeat (SAMPLES / 2) send_sample(pick_sample(SPREAD_UNIFORM, tmsf_pkg::SAMPLE_MIN));
        wait_drained();
        repeat (SAMPLES / 2) send_sample(pick_sample(SPREAD_RAILS, tmsf_pkg::SAMPLE_MIN));
        send_group(SPREAD_FLAT);
        wait_drained();
    endtask

    task automatic test_random_groups();
        int groups;
        while (samples_sent < ITEM_TARGET) begin
            wait_drained();
            write_gain(pick_gain());
            src_gaps_on  = ($urandom_range(0, 3) != 0);
            sink_gaps_on = ($urandom_range(0, 3) != 0);
            groups = $urandom_range(4, 16);
            repeat (groups) begin
                case ($urandom_range(0, 5))
                    0:       send_group(SPREAD_NARROW);
                    1:       send_group(SPREAD_RAILS);
                    2:       send_group(SPREAD_FLAT);
                    default: send_group(SPREAD_UNIFORM);
                endcase
            end
            if ($urandom_range(0, 3) == 0) begin
                repeat ($urandom_range(1, SAMPLES - 1))
                    send_sample(pick_sample(SPREAD_UNIFORM, tmsf_pkg::SAMPLE_MIN));
            end
        end
        wait_drained();
    endtask

    // result checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_means.size() == 0) begin
                report_mismatch("unexpected scaled_mean", 32'(m_tdata), 0);
            end else begin
                if (m_tdata !== expected_means[0]) begin
                    report_mismatch("scaled_mean", 32'(m_tdata), 32'(expected_means[0]));
                end
                void'(expected_means.pop_front());
            end
            sink_wait = sink_gaps_on ? $urandom_range(0, 3) : 0;
        end
    end

    initial begin : result_sink
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_hold_cycles > 0) begin
                m_tready <= 1'b0;
                sink_hold_cycles--;
            end else if (sink_wait > 0) begin
                m_tready <= 1'b0;
                sink_wait--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("[%0t] timeout: no transaction for %0d cycles", $time, IDLE_LIMIT);
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        filt_gain   = tmsf_pkg::GAIN_RESET;
        clear_group_state();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_groups();
        test_gain_extremes();
        test_output_backpressure();
        test_drain_pause();
        test_random_groups();

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
